// ===== rtl/tgrm_pkg.sv =====
`default_nettype none
package tgrm_pkg;

  localparam int unsigned MapWidthDef  = 64;
  localparam int unsigned MapHeightDef = 64;

  localparam int unsigned PosW   = 20;  // signed q12 coordinate
  localparam int unsigned MarchW = 22;  // march position with headroom
  localparam int unsigned DistW  = 20;  // marched distance
  localparam int unsigned MaxdW  = 19;
  localparam int unsigned DirW   = 16;
  localparam int unsigned TileW  = 6;
  localparam int unsigned SumW   = 32;  // dx*dx + dy*dy
  localparam int unsigned RadW   = 60;  // sum << 28
  localparam int unsigned RootW  = 30;
  localparam int unsigned NumW   = 44;  // |d| << 28 plus half root
  localparam int unsigned QuotW  = 15;
  localparam int unsigned CntW   = 5;

  localparam logic [DistW-1:0] StepQ12   = DistW'(410);
  localparam logic [8:0]       StepMul   = 9'd410;
  localparam logic [CntW-1:0]  RootIters = CntW'(RootW - 1);
  localparam logic [CntW-1:0]  DivIters  = CntW'(QuotW - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SQUARE,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DELTA,
    ST_MARCH,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic capture;
    logic clr;
    logic wr;
    logic sq_load;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic delta_load;
    logic march_step;
    logic fin_march;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_cast;
    logic iter_last;
    logic b_hit;
    logic a_end;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/tgrm_ram.sv =====
`default_nettype none
module tgrm_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/tgrm_ctrl.sv =====
`default_nettype none
module tgrm_ctrl
  import tgrm_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output      logic in_ready_o,
  input  wire sts_t sts_i,
  output      cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // captured word decides: tile write or cast setup
        if (sts_i.is_cast) begin
          state_d = ST_SQUARE;
        end else begin
          cmd_o.wr = 1'b1;
          state_d = ST_RESULT;
        end
      end
      ST_SQUARE: begin
        cmd_o.sq_load = 1'b1;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.iter_last) state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.iter_last) state_d = ST_DELTA;
      end
      ST_DELTA: begin
        cmd_o.delta_load = 1'b1;
        state_d = ST_MARCH;
      end
      ST_MARCH: begin
        priority if (sts_i.b_hit || sts_i.a_end) begin
          cmd_o.fin_march = 1'b1;
          state_d = ST_RESULT;
        end else begin
          cmd_o.march_step = 1'b1;
        end
      end
      ST_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/tgrm_dp.sv =====
`default_nettype none
module tgrm_dp
  import tgrm_pkg::*;
#(
  parameter int unsigned MAP_WIDTH  = MapWidthDef,
  parameter int unsigned MAP_HEIGHT = MapHeightDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cmd_t                    cmd_i,
  output      sts_t                    sts_o,
  input  wire logic                    func_i,
  input  wire logic [TileW-1:0]        write_tile_x_i,
  input  wire logic [TileW-1:0]        write_tile_y_i,
  input  wire logic                    solid_bit_i,
  input  wire logic signed [PosW-1:0]  origin_x_i,
  input  wire logic signed [PosW-1:0]  origin_y_i,
  input  wire logic signed [DirW-1:0]  dir_x_i,
  input  wire logic signed [DirW-1:0]  dir_y_i,
  input  wire logic [MaxdW-1:0]        max_distance_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic                    hit_o,
  output      logic signed [PosW-1:0]  hit_x_o,
  output      logic signed [PosW-1:0]  hit_y_o,
  output      logic [MaxdW-1:0]        hit_distance_o,
  output      logic [TileW-1:0]        hit_tile_x_o,
  output      logic [TileW-1:0]        hit_tile_y_o
);

  localparam int unsigned Depth = MAP_WIDTH * MAP_HEIGHT;
  localparam int unsigned AddrW = $clog2(Depth);

  // captured word
  logic                   func_q;
  logic [TileW-1:0]       wx_q, wy_q;
  logic                   solid_q;
  logic signed [PosW-1:0] ox_q, oy_q;
  logic signed [DirW-1:0] dx_q, dy_q;
  logic [MaxdW-1:0]       maxd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      wx_q    <= write_tile_x_i;
      wy_q    <= write_tile_y_i;
      solid_q <= solid_bit_i;
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      dx_q    <= dir_x_i;
      dy_q    <= dir_y_i;
      maxd_q  <= max_distance_i;
    end
  end

  // clearing pass counter
  logic [AddrW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  // squares and integer square root, one result bit per radicand pair
  logic signed [2*DirW-1:0] px, py;
  logic [SumW-1:0]  sum;
  logic [RadW-1:0]  rad_q;
  logic [SumW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic             szero_q;
  logic [CntW-1:0]  cnt_q;
  logic [SumW+1:0]  rsh, trial;

  assign px    = dx_q * dx_q;
  assign py    = dy_q * dy_q;
  assign sum   = SumW'(px) + SumW'(py);
  assign rsh   = {rem_q, rad_q[RadW-1 -: 2]};
  assign trial = {2'b00, root_q, 2'b01};

  // divider, both components side by side
  logic [DirW-1:0]  magx, magy;
  logic [NumW-1:0]  numx, numy;
  logic [RootW-1:0] drx_q, dry_q;
  logic [QuotW-1:0] nsx_q, nsy_q, qx_q, qy_q;
  logic [RootW:0]   tx_sh, ty_sh;

  assign magx  = dx_q[DirW-1] ? DirW'(-dx_q) : DirW'(dx_q);
  assign magy  = dy_q[DirW-1] ? DirW'(-dy_q) : DirW'(dy_q);
  assign numx  = {magx, 28'b0} + NumW'(root_q >> 1);
  assign numy  = {magy, 28'b0} + NumW'(root_q >> 1);
  assign tx_sh = {drx_q, nsx_q[QuotW-1]};
  assign ty_sh = {dry_q, nsy_q[QuotW-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_load) begin
      rad_q   <= {sum, 28'b0};
      rem_q   <= '0;
      root_q  <= '0;
      szero_q <= (sum == '0);
      cnt_q   <= RootIters;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= rad_q << 2;
      cnt_q <= cnt_q - CntW'(1);
      if (rsh >= trial) begin
        rem_q  <= SumW'(rsh - trial);
        root_q <= {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_q  <= SumW'(rsh);
        root_q <= {root_q[RootW-2:0], 1'b0};
      end
    end else if (cmd_i.div_init) begin
      drx_q <= RootW'(numx[NumW-1:QuotW]);
      dry_q <= RootW'(numy[NumW-1:QuotW]);
      nsx_q <= numx[QuotW-1:0];
      nsy_q <= numy[QuotW-1:0];
      qx_q  <= '0;
      qy_q  <= '0;
      cnt_q <= DivIters;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - CntW'(1);
      nsx_q <= nsx_q << 1;
      nsy_q <= nsy_q << 1;
      if (tx_sh >= {1'b0, root_q}) begin
        drx_q <= RootW'(tx_sh - {1'b0, root_q});
        qx_q  <= {qx_q[QuotW-2:0], 1'b1};
      end else begin
        drx_q <= RootW'(tx_sh);
        qx_q  <= {qx_q[QuotW-2:0], 1'b0};
      end
      if (ty_sh >= {1'b0, root_q}) begin
        dry_q <= RootW'(ty_sh - {1'b0, root_q});
        qy_q  <= {qy_q[QuotW-2:0], 1'b1};
      end else begin
        dry_q <= RootW'(ty_sh);
        qy_q  <= {qy_q[QuotW-2:0], 1'b0};
      end
    end
  end

  // step delta
  logic [QuotW+8:0]         prodx, prody;
  logic [9:0]               dmx, dmy;
  logic signed [MarchW-1:0] dlx_q, dly_q;

  assign prodx = (szero_q ? '0 : qx_q) * StepMul;
  assign prody = (szero_q ? '0 : qy_q) * StepMul;
  assign dmx   = 10'((prodx + (QuotW+9)'(8192)) >> 14);
  assign dmy   = 10'((prody + (QuotW+9)'(8192)) >> 14);

  // march: stage a looks up the tile, stage b sees the map bit
  logic signed [MarchW-1:0] ax_q, ay_q;
  logic [DistW-1:0]         ad_q;
  logic signed [PosW-1:0]   bx_q, by_q;
  logic [MaxdW-1:0]         bd_q;
  logic [TileW-1:0]         btx_q, bty_q;
  logic                     bv_q;
  logic                     in_rng, on_map;
  logic [AddrW-1:0]         raddr;
  logic                     rdata;

  assign in_rng = (ax_q[MarchW-1:PosW-1] == '0 || ax_q[MarchW-1:PosW-1] == '1) &&
                  (ay_q[MarchW-1:PosW-1] == '0 || ay_q[MarchW-1:PosW-1] == '1);
  assign on_map = !ax_q[PosW-1] && !ay_q[PosW-1] &&
                  (int'(ax_q[PosW-2:12]) < MAP_WIDTH) &&
                  (int'(ay_q[PosW-2:12]) < MAP_HEIGHT);
  assign raddr  = AddrW'(int'(ay_q[PosW-2:12]) * MAP_WIDTH + int'(ax_q[PosW-2:12]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.delta_load) begin
      dlx_q <= dx_q[DirW-1] ? -MarchW'(dmx) : MarchW'(dmx);
      dly_q <= dy_q[DirW-1] ? -MarchW'(dmy) : MarchW'(dmy);
      ax_q  <= MarchW'(ox_q);
      ay_q  <= MarchW'(oy_q);
      ad_q  <= '0;
      bv_q  <= 1'b0;
    end else if (cmd_i.march_step) begin
      bx_q  <= PosW'(ax_q);
      by_q  <= PosW'(ay_q);
      bd_q  <= MaxdW'(ad_q);
      btx_q <= ax_q[12 +: TileW];
      bty_q <= ay_q[12 +: TileW];
      bv_q  <= 1'b1;
      ax_q  <= ax_q + dlx_q;
      ay_q  <= ay_q + dly_q;
      ad_q  <= ad_q + StepQ12;
    end
  end

  // tile map
  logic             w_inmap;
  logic             ram_we;
  logic [AddrW-1:0] waddr;

  assign w_inmap = (int'(wx_q) < MAP_WIDTH) && (int'(wy_q) < MAP_HEIGHT);
  assign ram_we  = cmd_i.clr || (cmd_i.wr && w_inmap);
  assign waddr   = cmd_i.clr ? clr_q :
                   AddrW'(int'(wy_q) * MAP_WIDTH + int'(wx_q));

  tgrm_ram #(
    .Width (1),
    .Depth (Depth)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (cmd_i.clr ? 1'b0 : solid_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result
  logic res_hit_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_hit_q <= 1'b0;
    end else if (cmd_i.fin_march) begin
      res_hit_q <= bv_q && rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      hit_o          <= res_hit_q;
      hit_x_o        <= res_hit_q ? bx_q  : '0;
      hit_y_o        <= res_hit_q ? by_q  : '0;
      hit_distance_o <= res_hit_q ? bd_q  : '0;
      hit_tile_x_o   <= res_hit_q ? btx_q : '0;
      hit_tile_y_o   <= res_hit_q ? bty_q : '0;
    end
  end

  always_comb begin
    sts_o.clear_done = (clr_q == AddrW'(Depth - 1));
    sts_o.is_cast    = func_q;
    sts_o.iter_last  = (cnt_q == '0);
    sts_o.b_hit      = bv_q && rdata;
    sts_o.a_end      = ({1'b0, ad_q} >= (DistW+1)'(maxd_q)) || !in_rng || !on_map;
    sts_o.out_free   = !out_valid_o || out_ready_i;
  end

endmodule
`default_nettype wire

// ===== rtl/tile_grid_ray_march_top.sv =====
`default_nettype none
// channel  | handshake                | payload
// ---------+--------------------------+------------------------------------------------
// in       | in_valid_i / in_ready_o  | func, write_tile_x/y, solid_bit, origin_x/y,
//          |                          | dir_x/y, max_distance
// out      | out_valid_o / out_ready_i| hit, hit_x/y, hit_distance, hit_tile_x/y
//
// a tile write passes through accept, write and result load
// a cast runs its setup (accept, decode, squares, 30-step square root, divider
// load, 15-step divide, step delta), then one march step per cycle, then a check
// of the last map read, then the result load
// after reset a clearing pass zeroes all MAP_WIDTH*MAP_HEIGHT tiles of the map,
// during which no word is taken
// a finished result waits in the output register; the next word is taken
// meanwhile and its result holds until the output register frees
module tile_grid_ray_march_top
  import tgrm_pkg::*;
#(
  parameter int unsigned MAP_WIDTH  = MapWidthDef,
  parameter int unsigned MAP_HEIGHT = MapHeightDef
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output      logic                    in_ready_o,
  input  wire logic                    func_i,
  input  wire logic [TileW-1:0]        write_tile_x_i,
  input  wire logic [TileW-1:0]        write_tile_y_i,
  input  wire logic                    solid_bit_i,
  input  wire logic signed [PosW-1:0]  origin_x_i,
  input  wire logic signed [PosW-1:0]  origin_y_i,
  input  wire logic signed [DirW-1:0]  dir_x_i,
  input  wire logic signed [DirW-1:0]  dir_y_i,
  input  wire logic [MaxdW-1:0]        max_distance_i,
  output      logic                    out_valid_o,
  input  wire logic                    out_ready_i,
  output      logic                    hit_o,
  output      logic signed [PosW-1:0]  hit_x_o,
  output      logic signed [PosW-1:0]  hit_y_o,
  output      logic [MaxdW-1:0]        hit_distance_o,
  output      logic [TileW-1:0]        hit_tile_x_o,
  output      logic [TileW-1:0]        hit_tile_y_o
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: clear pass, setup steps and march loop
  tgrm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: normalisation units, two-stage marcher, tile map and output register
  tgrm_dp #(
    .MAP_WIDTH  (MAP_WIDTH),
    .MAP_HEIGHT (MAP_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (func_i),
    .write_tile_x_i (write_tile_x_i),
    .write_tile_y_i (write_tile_y_i),
    .solid_bit_i    (solid_bit_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .max_distance_i (max_distance_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .hit_x_o        (hit_x_o),
    .hit_y_o        (hit_y_o),
    .hit_distance_o (hit_distance_o),
    .hit_tile_x_o   (hit_tile_x_o),
    .hit_tile_y_o   (hit_tile_y_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb_tile_grid_ray_march_top.sv =====
`default_nettype none
module tb_tile_grid_ray_march_top;
  import tgrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 440;
  localparam int MapW = 64;
  localparam int MapH = 64;

  // one word in, one word out
  typedef struct {
    bit          func;
    bit [5:0]    tile_x;
    bit [5:0]    tile_y;
    bit          solid;
    int          org_x;
    int          org_y;
    int          dir_x;
    int          dir_y;
    int unsigned limit;
  } ray_word_t;

  typedef struct {
    bit          hit;
    int          pos_x;
    int          pos_y;
    int unsigned distance;
    int          tile_x;
    int          tile_y;
  } hit_word_t;

  // keeps its own copy of the tile map and the queue of predicted hit words
  class ray_scoreboard;
    bit          solid_tiles [MapW*MapH];
    hit_word_t   pending_hits [$];
    int          errors;
    int          casts;
    int          hits;

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= root + bitv) begin
          v -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root;
    endfunction

    function int unit_comp(int d, longint unsigned r);
      longint unsigned mag;
      longint unsigned q;
      mag = (d < 0) ? -d : d;
      q = ((mag << 28) + (r >> 1)) / r;
      return (d < 0) ? -int'(q) : int'(q);
    endfunction

    function int step_comp(int n);
      int unsigned mag;
      int q;
      mag = (n < 0) ? -n : n;
      q = int'((mag * 410 + 8192) >> 14);
      return (n < 0) ? -q : q;
    endfunction

    // tile index of a q12 coordinate, floored
    function int tile_of(int p);
      return ((p + 524288) >>> 12) - 128;
    endfunction

    function void note_word(ray_word_t w);
      hit_word_t   res;
      longint      sq;
      longint unsigned root;
      int          ux, uy, sx, sy, px, py, tx, ty;
      int unsigned marched;
      res = '{default: 0};
      if (!w.func) begin
        if (w.tile_x < MapW && w.tile_y < MapH)
          solid_tiles[int'(w.tile_y) * MapW + int'(w.tile_x)] = w.solid;
        pending_hits.push_back(res);
        return;
      end
      casts++;
      ux = 0;
      uy = 0;
      sq = longint'(w.dir_x) * w.dir_x + longint'(w.dir_y) * w.dir_y;
      if (sq != 0) begin
        root = int_sqrt(longint'(sq) << 28);
        ux = unit_comp(w.dir_x, root);
        uy = unit_comp(w.dir_y, root);
      end
      sx = step_comp(ux);
      sy = step_comp(uy);
      px = w.org_x;
      py = w.org_y;
      marched = 0;
      while (marched < w.limit) begin
        // leaving the coordinate range counts as leaving the map
        if (px < -524288 || px > 524287 || py < -524288 || py > 524287) break;
        tx = tile_of(px);
        ty = tile_of(py);
        if (tx < 0 || ty < 0 || tx >= MapW || ty >= MapH) break;
        if (solid_tiles[ty * MapW + tx]) begin
          res = '{hit: 1'b1, pos_x: px, pos_y: py, distance: marched, tile_x: tx,
                  tile_y: ty};
          hits++;
          break;
        end
        px += sx;
        py += sy;
        marched += 410;
      end
      pending_hits.push_back(res);
    endfunction

    function void cmp_field(string name, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_word(hit_word_t act);
      hit_word_t exp_w;
      if (pending_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, hit %0d", $time, act.hit);
        return;
      end
      exp_w = pending_hits.pop_front();
      cmp_field("hit", exp_w.hit, act.hit);
      cmp_field("hit_x", exp_w.pos_x, act.pos_x);
      cmp_field("hit_y", exp_w.pos_y, act.pos_y);
      cmp_field("hit_distance", exp_w.distance, act.distance);
      cmp_field("hit_tile_x", exp_w.tile_x, act.tile_x);
      cmp_field("hit_tile_y", exp_w.tile_y, act.tile_y);
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic                   func_i = 1'b0;
  logic [TileW-1:0]       write_tile_x_i = '0;
  logic [TileW-1:0]       write_tile_y_i = '0;
  logic                   solid_bit_i = 1'b0;
  logic signed [PosW-1:0] origin_x_i = '0;
  logic signed [PosW-1:0] origin_y_i = '0;
  logic signed [DirW-1:0] dir_x_i = '0;
  logic signed [DirW-1:0] dir_y_i = '0;
  logic [MaxdW-1:0]       max_distance_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic                   hit_o;
  logic signed [PosW-1:0] hit_x_o;
  logic signed [PosW-1:0] hit_y_o;
  logic [MaxdW-1:0]       hit_distance_o;
  logic [TileW-1:0]       hit_tile_x_o;
  logic [TileW-1:0]       hit_tile_y_o;

  ray_scoreboard sb = new();

  // idling percentages of the current phase
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  always #5 clk_i = ~clk_i;

  tile_grid_ray_march_top i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .func_i         (func_i),
    .write_tile_x_i (write_tile_x_i),
    .write_tile_y_i (write_tile_y_i),
    .solid_bit_i    (solid_bit_i),
    .origin_x_i     (origin_x_i),
    .origin_y_i     (origin_y_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .max_distance_i (max_distance_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .hit_x_o        (hit_x_o),
    .hit_y_o        (hit_y_o),
    .hit_distance_o (hit_distance_o),
    .hit_tile_x_o   (hit_tile_x_o),
    .hit_tile_y_o   (hit_tile_y_o)
  );

  // result side: check on each handshake, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_word('{hit: hit_o, pos_x: int'(hit_x_o), pos_y: int'(hit_y_o),
                      distance: 32'(hit_distance_o), tile_x: int'(hit_tile_x_o),
                      tile_y: int'(hit_tile_y_o)});
    end
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // present one word, holding it until the block takes it
  task automatic send_word(ray_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= w.func;
    write_tile_x_i <= w.tile_x;
    write_tile_y_i <= w.tile_y;
    solid_bit_i    <= w.solid;
    origin_x_i     <= PosW'(w.org_x);
    origin_y_i     <= PosW'(w.org_y);
    dir_x_i        <= DirW'(w.dir_x);
    dir_y_i        <= DirW'(w.dir_y);
    max_distance_i <= MaxdW'(w.limit);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_word(w);
  endtask

  // tile write word; the cast fields carry noise
  function automatic ray_word_t tile_write(int tx, int ty, bit s);
    ray_word_t w;
    w = '{func: 1'b0, tile_x: 6'(tx), tile_y: 6'(ty), solid: s,
          org_x: int'($signed(20'($urandom))), org_y: int'($signed(20'($urandom))),
          dir_x: int'($signed(16'($urandom))), dir_y: int'($signed(16'($urandom))),
          limit: $urandom_range(524287)};
    return w;
  endfunction

  function automatic ray_word_t ray_cast(int ox, int oy, int dx, int dy, int unsigned lim);
    ray_word_t w;
    w = '{func: 1'b1, tile_x: 6'($urandom), tile_y: 6'($urandom), solid: 1'($urandom),
          org_x: ox, org_y: oy, dir_x: dx, dir_y: dy, limit: lim};
    return w;
  endfunction

  // mostly in-map casts with short limits, a few anywhere and long
  function automatic ray_word_t random_cast();
    int ox, oy, dx, dy;
    int unsigned lim;
    if ($urandom_range(9) == 0) begin
      ox = int'($signed(20'($urandom)));
      oy = int'($signed(20'($urandom)));
    end else begin
      ox = $urandom_range(MapW * 4096 - 1);
      oy = $urandom_range(MapH * 4096 - 1);
    end
    case ($urandom_range(9))
      0:       begin dx = 0; dy = 0; end
      1, 2:    begin
        dx = int'($signed(4'($urandom)));
        dy = int'($signed(4'($urandom)));
      end
      default: begin
        dx = int'($signed(16'($urandom)));
        dy = int'($signed(16'($urandom)));
      end
    endcase
    if ($urandom_range(24) == 0) lim = $urandom_range(524287);
    else lim = $urandom_range(60000);
    return ray_cast(ox, oy, dx, dy, lim);
  endfunction

  initial begin
    int phase;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tiles at two map corners and at (10,5), then casts at the edge cases
    send_word(tile_write(0, 0, 1));
    send_word(tile_write(63, 63, 1));
    send_word(tile_write(10, 5, 1));
    send_word(ray_cast(100, 200, 0, 0, 1));              // zero direction, solid origin
    send_word(ray_cast(100, 200, 0, 0, 0));              // zero limit
    send_word(ray_cast(5 * 4096, 5 * 4096 + 100, 1, 0, 524287));  // march into a wall
    send_word(ray_cast(63 * 4096 + 4095, 63 * 4096 + 4095, -32768, -32768, 4000));
    send_word(ray_cast(2 * 4096, 2 * 4096, -32768, -32768, 524287)); // toward corner tile
    send_word(ray_cast(-524288, -524288, 32767, 32767, 524287));   // far off the map
    send_word(ray_cast(524287, 524287, -1, 0, 524287));            // top of range
    send_word(ray_cast(100, 100, 0, 32767, 0));
    send_word(ray_cast(-1, 100, 1, 0, 1000));            // just left of the map
    send_word(ray_cast(20 * 4096, 20 * 4096, 0, 0, 50)); // zero direction, empty tile
    send_word(tile_write(10, 5, 0));
    send_word(tile_write(0, 0, 0));
    send_word(ray_cast(5 * 4096, 5 * 4096 + 100, 1, 0, 30000)); // wall now cleared
    send_word(ray_cast(100, 200, 0, 0, 524287));
    send_word(tile_write(32, 31, 1));
    send_word(ray_cast(32 * 4096 + 2048, 2048, 0, 16384, 300000));

    // random: four idling phases
    for (int i = 0; i < NumRandom; i++) begin
      phase = i * 4 / NumRandom;
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if ($urandom_range(99) < 35)
        send_word(tile_write($urandom_range(63), $urandom_range(63), $urandom_range(3) != 0));
      else
        send_word(random_cast());
    end
    in_valid_i <= 1'b0;

    // drain and let the block settle
    while (sb.pending_hits.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);

    $display("tb: %0d casts checked, %0d of them hit a tile, under four idling phases",
             sb.casts, sb.hits);
    if (sb.errors == 0 && sb.pending_hits.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hang guard, covering the clearing pass and slow stalled casts
  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/tgrm_pkg.sv
rtl/tgrm_ram.sv
rtl/tgrm_ctrl.sv
rtl/tgrm_dp.sv
rtl/tile_grid_ray_march_top.sv
tb/tb_tile_grid_ray_march_top.sv
